@@ rtl/core/vvu_pkg.sv @@
// Package for the three-component vector unit: word format, opcodes,
// pipeline payload type and the saturating clamp. No dependencies.
`default_nettype none
package vvu_pkg;

    localparam int WORD_BITS   = 32;
    localparam int FRAC_BITS   = 16;
    localparam int EFF_BITS    = (WORD_BITS < 32) ? WORD_BITS : 32;
    localparam int EPS_BITS    = 16;
    localparam int OP_BITS     = 3;
    localparam int PROD_BITS   = 2 * EFF_BITS;
    localparam int SAT_IN_BITS = 2 * EFF_BITS + 2;
    localparam int SQRT_STAGES = EFF_BITS;
    localparam int QUO_BITS    = FRAC_BITS + 1;
    localparam longint WORD_MAX = (64'sd1 <<< (EFF_BITS - 1)) - 64'sd1;
    localparam longint WORD_MIN = -WORD_MAX - 64'sd1;

    typedef logic signed [EFF_BITS-1:0] t_word;

    typedef enum logic [OP_BITS-1:0] {
        OP_SUB   = 3'd0,
        OP_LEN   = 3'd1,
        OP_NORM  = 3'd2,
        OP_CROSS = 3'd3,
        OP_DOT   = 3'd4,
        OP_EQUAL = 3'd5
    } t_op;

    // Everything an item carries down the pipeline besides the datapath.
    typedef struct packed {
        logic [OP_BITS-1:0] op;
        t_word [2:0]        r;
        t_word              sc;
        logic               eq;
        logic               sat;
        logic               keep;
        t_word [2:0]        a;
    } t_payload;

    typedef struct packed {
        t_word val;
        logic  sat;
    } t_sat;

    function automatic t_sat sat_word(input logic signed [SAT_IN_BITS-1:0] v);
        t_sat res;
        if (v > SAT_IN_BITS'(WORD_MAX)) begin
            res.val = EFF_BITS'(WORD_MAX);
            res.sat = 1'b1;
        end else if (v < SAT_IN_BITS'(WORD_MIN)) begin
            res.val = EFF_BITS'(WORD_MIN);
            res.sat = 1'b1;
        end else begin
            res.val = v[EFF_BITS-1:0];
            res.sat = 1'b0;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/vvu_if.sv @@
// Request and response channel interfaces of the vector unit.
// Depends on vvu_pkg for the word and opcode widths.
`default_nettype none
interface vvu_in_if
    import vvu_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [OP_BITS-1:0] opcode;
    t_word              ax;
    t_word              ay;
    t_word              az;
    t_word              bx;
    t_word              by;
    t_word              bz;

    modport source (output valid, opcode, ax, ay, az, bx, by, bz, input ready);
    modport sink   (input valid, opcode, ax, ay, az, bx, by, bz, output ready);
endinterface

interface vvu_out_if
    import vvu_pkg::*;
();
    logic  valid;
    logic  ready;
    t_word rx;
    t_word ry;
    t_word rz;
    t_word scalar;
    logic  equal;
    logic  saturated;

    modport source (output valid, rx, ry, rz, scalar, equal, saturated, input ready);
    modport sink   (input valid, rx, ry, rz, scalar, equal, saturated, output ready);
endinterface
`default_nettype wire

@@ rtl/core/vvu_lane.sv @@
// One component lane: difference, square, dot term and the two cross terms.
// Depends on vvu_pkg.
`default_nettype none
module vvu_lane
    import vvu_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire t_word                    i_a,
    input  wire t_word                    i_b,
    input  wire t_word                    i_a_j,
    input  wire t_word                    i_b_k,
    input  wire t_word                    i_a_k,
    input  wire t_word                    i_b_j,
    output logic signed [EFF_BITS:0]      o_diff,
    output logic [PROD_BITS-1:0]          o_sq,
    output logic signed [PROD_BITS-1:0]   o_dot,
    output logic signed [PROD_BITS-1:0]   o_cp,
    output logic signed [PROD_BITS-1:0]   o_cn
);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_diff <= (EFF_BITS+1)'(i_a) - (EFF_BITS+1)'(i_b);
            o_sq   <= PROD_BITS'(PROD_BITS'(i_a) * PROD_BITS'(i_a));
            o_dot  <= PROD_BITS'(i_a) * PROD_BITS'(i_b);
            o_cp   <= PROD_BITS'(i_a_j) * PROD_BITS'(i_b_k);
            o_cn   <= PROD_BITS'(i_a_k) * PROD_BITS'(i_b_j);
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/vvu_sqrt.sv @@
// Pipelined floor square root, one result bit per stage.
// Depends on vvu_pkg.
`default_nettype none
module vvu_sqrt
    import vvu_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic [PROD_BITS-1:0]   i_rad,
    output logic [EFF_BITS-1:0]         o_root
);

    localparam int REM_BITS = EFF_BITS + 4;

    logic [PROD_BITS-1:0] r_rad  [SQRT_STAGES];
    logic [REM_BITS-1:0]  r_rem  [SQRT_STAGES];
    logic [EFF_BITS-1:0]  r_root [SQRT_STAGES];

    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_st
        logic [PROD_BITS-1:0] rad_in;
        logic [REM_BITS-1:0]  rem_in;
        logic [EFF_BITS-1:0]  root_in;
        logic [REM_BITS-1:0]  rem_sh;
        logic [REM_BITS-1:0]  trial;

        if (s == 0) begin : g_first
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign rad_in  = r_rad[s-1];
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
        end

        // Bring down the next pair of radicand bits and try 4*root+1.
        assign rem_sh = {rem_in[REM_BITS-3:0], rad_in[2*(SQRT_STAGES-1-s)+1 -: 2]};
        assign trial  = {{(REM_BITS-2-EFF_BITS){1'b0}}, root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[s] <= rad_in;
                if (rem_sh >= trial) begin
                    r_rem[s]  <= rem_sh - trial;
                    r_root[s] <= {root_in[EFF_BITS-2:0], 1'b1};
                end else begin
                    r_rem[s]  <= rem_sh;
                    r_root[s] <= {root_in[EFF_BITS-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];

endmodule
`default_nettype wire

@@ rtl/core/vvu_div.sv @@
// Pipelined restoring divider: (num * 2^FRAC_BITS) / den, one quotient bit
// per stage. The quotient is known to fit QUO_BITS. Depends on vvu_pkg.
`default_nettype none
module vvu_div
    import vvu_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [EFF_BITS-1:0]   i_num,
    input  wire logic [EFF_BITS-1:0]   i_den,
    output logic [QUO_BITS-1:0]        o_quo
);

    logic [EFF_BITS-1:0] r_rem [QUO_BITS];
    logic [EFF_BITS-1:0] r_den [QUO_BITS];
    logic [QUO_BITS-1:0] r_quo [QUO_BITS];

    for (genvar s = 0; s < QUO_BITS; s++) begin : g_st
        logic [EFF_BITS:0]   rem_sh;
        logic [EFF_BITS-1:0] den_in;
        logic [QUO_BITS-1:0] quo_in;

        if (s == 0) begin : g_first
            // The bits above the quotient range are already below den.
            assign rem_sh = {1'b0, i_num};
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_sh = {r_rem[s-1], 1'b0};
            assign den_in = r_den[s-1];
            assign quo_in = r_quo[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s] <= den_in;
                if (rem_sh >= {1'b0, den_in}) begin
                    r_rem[s] <= EFF_BITS'(rem_sh - {1'b0, den_in});
                    r_quo[s] <= {quo_in[QUO_BITS-2:0], 1'b1};
                end else begin
                    r_rem[s] <= rem_sh[EFF_BITS-1:0];
                    r_quo[s] <= {quo_in[QUO_BITS-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo = r_quo[QUO_BITS-1];

endmodule
`default_nettype wire

@@ rtl/core/vec3_vector_unit_top.sv @@
// Top level of the three-component vector unit: lanes, merge, square root
// and divider pipelines. Depends on vvu_pkg, vvu_if, vvu_lane, vvu_sqrt, vvu_div.
//
// Usage: a request on i_req carries an opcode and two Q16.16 vectors a and
// b; every request yields exactly one response on o_rsp with the vector
// result, the scalar result, the equality flag and the saturation flag.
// Both channels use a valid/ready handshake; a transfer happens on a
// rising edge of i_clk where valid and ready are both high.
// The datapath is one pipeline shared by all opcodes: three lanes (one per
// component), a merge stage, a 32-stage square root (one root bit per
// stage) and a 17-stage divider (one quotient bit per stage) for normalize,
// then the output register. A new request is taken every cycle unless
// back-pressure on o_rsp has frozen the pipeline.
// When the receiver holds o_rsp.ready low with a response pending, the
// whole pipeline freezes and i_req.ready drops in the same cycle; nothing
// is lost or repeated.
// The user must write the epsilon register through i_cfg_we/i_cfg_wdata
// only while the unit is idle; the block does not enforce this. Reset
// (i_rst_n low, synchronous) empties the pipeline and sets epsilon to 1.
`default_nettype none
module vec3_vector_unit_top
    import vvu_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [EPS_BITS-1:0]  i_cfg_wdata,
    vvu_in_if.sink                    i_req,
    vvu_out_if.source                 o_rsp
);

    localparam int LEN_BITS = EFF_BITS;

    logic w_en;
    logic [EPS_BITS-1:0] r_eps;

    // Whole pipeline advances unless a response is waiting and stalled.
    assign w_en        = !o_rsp.valid || o_rsp.ready;
    assign i_req.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_BITS'(1);
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    // Stage 1: lanes compute the per-component products and differences.
    t_word w_a [3];
    t_word w_b [3];
    logic signed [EFF_BITS:0]    w_diff [3];
    logic [PROD_BITS-1:0]        w_sq   [3];
    logic signed [PROD_BITS-1:0] w_dot  [3];
    logic signed [PROD_BITS-1:0] w_cp   [3];
    logic signed [PROD_BITS-1:0] w_cn   [3];

    assign w_a[0] = i_req.ax;
    assign w_a[1] = i_req.ay;
    assign w_a[2] = i_req.az;
    assign w_b[0] = i_req.bx;
    assign w_b[1] = i_req.by;
    assign w_b[2] = i_req.bz;

    for (genvar i = 0; i < 3; i++) begin : g_lane
        vvu_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_a    (w_a[i]),
            .i_b    (w_b[i]),
            .i_a_j  (w_a[(i+1)%3]),
            .i_b_k  (w_b[(i+2)%3]),
            .i_a_k  (w_a[(i+2)%3]),
            .i_b_j  (w_b[(i+1)%3]),
            .o_diff (w_diff[i]),
            .o_sq   (w_sq[i]),
            .o_dot  (w_dot[i]),
            .o_cp   (w_cp[i]),
            .o_cn   (w_cn[i])
        );
    end

    logic               r_s1_vld;
    logic [OP_BITS-1:0] r_s1_op;
    t_word [2:0]        r_s1_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_op <= i_req.opcode;
            for (int i = 0; i < 3; i++) begin
                r_s1_a[i] <= w_a[i];
            end
        end
    end

    // Stage 2: merge the lane results into the final values of every opcode
    // that needs neither the square root nor the divider.
    t_payload n_m;
    logic [PROD_BITS-1:0] n_sqsum;
    logic signed [PROD_BITS:0]       w_cr_full [3];
    logic signed [PROD_BITS:0]       w_cr_sh   [3];
    t_sat                            w_sub_s   [3];
    t_sat                            w_cr_s    [3];
    logic [EFF_BITS:0]               w_adiff   [3];
    logic signed [SAT_IN_BITS-1:0]   w_dsum;
    logic signed [SAT_IN_BITS-1:0]   w_dsh;
    t_sat                            w_dot_s;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sub_s[i]   = sat_word(SAT_IN_BITS'(w_diff[i]));
            w_cr_full[i] = (PROD_BITS+1)'(w_cp[i]) - (PROD_BITS+1)'(w_cn[i]);
            w_cr_sh[i]   = w_cr_full[i] >>> FRAC_BITS;
            w_cr_s[i]    = sat_word(SAT_IN_BITS'(w_cr_sh[i]));
            w_adiff[i]   = w_diff[i][EFF_BITS] ? (EFF_BITS+1)'(-w_diff[i])
                                               : (EFF_BITS+1)'(w_diff[i]);
        end
        // The sum is floored once, as a whole, by the arithmetic shift.
        w_dsum  = SAT_IN_BITS'(w_dot[0]) + SAT_IN_BITS'(w_dot[1])
                + SAT_IN_BITS'(w_dot[2]);
        w_dsh   = w_dsum >>> FRAC_BITS;
        w_dot_s = sat_word(w_dsh);
        n_sqsum = w_sq[0] + w_sq[1] + w_sq[2];

        n_m      = '0;
        n_m.op   = r_s1_op;
        n_m.a    = r_s1_a;
        case (r_s1_op)
            OP_SUB: begin
                for (int i = 0; i < 3; i++) begin
                    n_m.r[i] = w_sub_s[i].val;
                end
                n_m.sat = w_sub_s[0].sat | w_sub_s[1].sat | w_sub_s[2].sat;
            end
            OP_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    n_m.r[i] = w_cr_s[i].val;
                end
                n_m.sat = w_cr_s[0].sat | w_cr_s[1].sat | w_cr_s[2].sat;
            end
            OP_DOT: begin
                n_m.sc  = w_dot_s.val;
                n_m.sat = w_dot_s.sat;
            end
            OP_EQUAL: begin
                n_m.eq = (w_adiff[0] < (EFF_BITS+1)'(r_eps))
                       && (w_adiff[1] < (EFF_BITS+1)'(r_eps))
                       && (w_adiff[2] < (EFF_BITS+1)'(r_eps));
            end
            default: begin
                n_m.sat = 1'b0;
            end
        endcase
    end

    logic                 r_m_vld;
    t_payload             r_m;
    logic [PROD_BITS-1:0] r_sqsum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (w_en) begin
            r_m_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m     <= n_m;
            r_sqsum <= n_sqsum;
        end
    end

    // Square root pipeline, payload travels alongside.
    logic [LEN_BITS-1:0] w_len;
    logic                r_sq_vld [SQRT_STAGES];
    t_payload            r_sq     [SQRT_STAGES];

    vvu_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_sqsum),
        .o_root (w_len)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SQRT_STAGES; s++) begin
                r_sq_vld[s] <= 1'b0;
            end
        end else if (w_en) begin
            r_sq_vld[0] <= r_m_vld;
            for (int s = 1; s < SQRT_STAGES; s++) begin
                r_sq_vld[s] <= r_sq_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq[0] <= r_m;
            for (int s = 1; s < SQRT_STAGES; s++) begin
                r_sq[s] <= r_sq[s-1];
            end
        end
    end

    // Length results and the short-vector test for normalize.
    t_payload            n_dv;
    t_sat                w_len_s;
    logic [EFF_BITS-1:0] w_mag [3];

    always_comb begin
        w_len_s = sat_word(SAT_IN_BITS'({1'b0, w_len}));
        n_dv    = r_sq[SQRT_STAGES-1];
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = n_dv.a[i][EFF_BITS-1] ? EFF_BITS'(-n_dv.a[i])
                                             : EFF_BITS'(n_dv.a[i]);
        end
        case (n_dv.op)
            OP_LEN: begin
                n_dv.sc  = w_len_s.val;
                n_dv.sat = w_len_s.sat;
            end
            OP_NORM: begin
                // A zero or below-epsilon length returns a as it is.
                if ((w_len == '0) || (w_len < LEN_BITS'(r_eps))) begin
                    n_dv.keep = 1'b1;
                    n_dv.r    = n_dv.a;
                end
            end
            default: begin
                n_dv.keep = 1'b0;
            end
        endcase
    end

    // Divider lanes, one per component.
    logic [QUO_BITS-1:0] w_quo [3];
    logic                r_dv_vld [QUO_BITS];
    t_payload            r_dv     [QUO_BITS];

    for (genvar i = 0; i < 3; i++) begin : g_div
        vvu_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_mag[i]),
            .i_den (w_len),
            .o_quo (w_quo[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < QUO_BITS; s++) begin
                r_dv_vld[s] <= 1'b0;
            end
        end else if (w_en) begin
            r_dv_vld[0] <= r_sq_vld[SQRT_STAGES-1];
            for (int s = 1; s < QUO_BITS; s++) begin
                r_dv_vld[s] <= r_dv_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv[0] <= n_dv;
            for (int s = 1; s < QUO_BITS; s++) begin
                r_dv[s] <= r_dv[s-1];
            end
        end
    end

    // Apply the quotient sign (truncation toward zero) and register out.
    t_payload n_out;
    t_word    w_q [3];

    always_comb begin
        n_out = r_dv[QUO_BITS-1];
        for (int i = 0; i < 3; i++) begin
            w_q[i] = EFF_BITS'(w_quo[i]);
        end
        if ((n_out.op == OP_NORM) && !n_out.keep) begin
            for (int i = 0; i < 3; i++) begin
                n_out.r[i] = n_out.a[i][EFF_BITS-1] ? -w_q[i] : w_q[i];
            end
        end
    end

    logic     r_out_vld;
    t_payload r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_dv_vld[QUO_BITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.rx        = r_out.r[0];
    assign o_rsp.ry        = r_out.r[1];
    assign o_rsp.rz        = r_out.r[2];
    assign o_rsp.scalar    = r_out.sc;
    assign o_rsp.equal     = r_out.eq;
    assign o_rsp.saturated = r_out.sat;

endmodule
`default_nettype wire

@@ bench/tb_vec3_checker.sv @@
// Checker for the vector unit: watches the request and response channels,
// predicts each response from its request and compares them.
// Depends on vvu_pkg and vvu_if.
module tb_vec3_checker
    import vvu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [EPS_BITS-1:0] i_cfg_wdata,
    vvu_in_if.source          i_req,
    vvu_out_if.sink           o_rsp,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct {
        longint rx;
        longint ry;
        longint rz;
        longint sc;
        bit     eq;
        bit     sat;
    } t_vec_result;

    t_vec_result result_fifo[$];
    longint unsigned eps_q = 1;

    assign o_pending = result_fifo.size();

    function automatic longint clamp_to_word(input longint v, inout bit sat);
        if (v > WORD_MAX) begin
            sat = 1;
            return WORD_MAX;
        end
        if (v < WORD_MIN) begin
            sat = 1;
            return WORD_MIN;
        end
        return v;
    endfunction

    // Floor of a sum of exact products scaled down by 2^FRAC_BITS.
    function automatic longint floor_scaled(input logic signed [127:0] s);
        logic signed [127:0] q;
        q = s >>> FRAC_BITS;
        return clamp_guard(q);
    endfunction

    function automatic longint clamp_guard(input logic signed [127:0] q);
        if (q > 128'sd9223372036854775807) return 64'sh7fffffffffffffff;
        if (q < -128'sd9223372036854775807) return -64'sh7fffffffffffffff;
        return longint'(q);
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic t_vec_result predict_vec(input logic [OP_BITS-1:0] op,
                                                input longint a[3], input longint b[3]);
        t_vec_result r;
        longint unsigned sumsq, len, mag;
        logic signed [127:0] p;
        longint d;
        r = '{0, 0, 0, 0, 0, 0};
        sumsq = 0;
        for (int i = 0; i < 3; i++) begin
            mag = (a[i] < 0) ? -a[i] : a[i];
            sumsq += mag * mag;
        end
        case (op)
            OP_SUB: begin
                r.rx = clamp_to_word(a[0] - b[0], r.sat);
                r.ry = clamp_to_word(a[1] - b[1], r.sat);
                r.rz = clamp_to_word(a[2] - b[2], r.sat);
            end
            OP_LEN: r.sc = clamp_to_word(longint'(root_floor(sumsq)), r.sat);
            OP_NORM: begin
                len = root_floor(sumsq);
                if (len == 0 || len < eps_q) begin
                    r.rx = a[0];
                    r.ry = a[1];
                    r.rz = a[2];
                end else begin
                    // Signed division truncates toward zero.
                    r.rx = clamp_to_word((a[0] <<< FRAC_BITS) / longint'(len), r.sat);
                    r.ry = clamp_to_word((a[1] <<< FRAC_BITS) / longint'(len), r.sat);
                    r.rz = clamp_to_word((a[2] <<< FRAC_BITS) / longint'(len), r.sat);
                end
            end
            OP_CROSS: begin
                p = 128'(a[1] * b[2]) - 128'(a[2] * b[1]);
                r.rx = clamp_to_word(floor_scaled(p), r.sat);
                p = 128'(a[2] * b[0]) - 128'(a[0] * b[2]);
                r.ry = clamp_to_word(floor_scaled(p), r.sat);
                p = 128'(a[0] * b[1]) - 128'(a[1] * b[0]);
                r.rz = clamp_to_word(floor_scaled(p), r.sat);
            end
            OP_DOT: begin
                p = 128'(a[0] * b[0]) + 128'(a[1] * b[1]) + 128'(a[2] * b[2]);
                r.sc = clamp_to_word(floor_scaled(p), r.sat);
            end
            OP_EQUAL: begin
                r.eq = 1;
                for (int i = 0; i < 3; i++) begin
                    d = a[i] - b[i];
                    if (d < 0) d = -d;
                    if (longint'(d) >= longint'(eps_q)) r.eq = 0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        longint a[3], b[3];
        t_vec_result want;
        if (!i_rst_n) begin
            eps_q = 1;
            result_fifo.delete();
        end else begin
            if (i_cfg_we) eps_q = i_cfg_wdata;
            if (i_req.valid && i_req.ready) begin
                a = '{longint'(i_req.ax), longint'(i_req.ay), longint'(i_req.az)};
                b = '{longint'(i_req.bx), longint'(i_req.by), longint'(i_req.bz)};
                result_fifo.push_back(predict_vec(i_req.opcode, a, b));
            end
            if (o_rsp.valid && o_rsp.ready) begin
                if (result_fifo.size() == 0) begin
                    $error("response with no request waiting");
                    o_fail_count++;
                end else begin
                    want = result_fifo.pop_front();
                    compare_field("rx", want.rx, longint'(o_rsp.rx));
                    compare_field("ry", want.ry, longint'(o_rsp.ry));
                    compare_field("rz", want.rz, longint'(o_rsp.rz));
                    compare_field("scalar", want.sc, longint'(o_rsp.scalar));
                    compare_field("equal", want.eq, o_rsp.equal);
                    compare_field("saturated", want.sat, o_rsp.saturated);
                end
            end
        end
    end

endmodule

@@ bench/tb_vec3_vector_unit_top.sv @@
// Top of the vector unit bench: clock, reset, request and configuration
// stimulus, response back-pressure and the verdict.
// Depends on vvu_pkg, vvu_if, the unit top and tb_vec3_checker.
module tb_vec3_vector_unit_top;
    import vvu_pkg::*;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [EPS_BITS-1:0] i_cfg_wdata;
    int                  fail_count;
    int                  pending;
    bit                  idle_off;

    vvu_in_if  req_if ();
    vvu_out_if rsp_if ();

    vec3_vector_unit_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if.sink),
        .o_rsp       (rsp_if.source)
    );

    tb_vec3_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req        (req_if.source),
        .o_rsp        (rsp_if.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls about a third of the time, except while idle_off
    // marks the stretch with no gaps on either side.
    initial rsp_if.ready = 0;
    always @(posedge i_clk) begin
        rsp_if.ready <= idle_off || ($urandom_range(99) >= 33);
    end

    // Picks a word that often sits on an edge of the range, otherwise a
    // mix of small Q16.16 values and fully random bits.
    function automatic t_word pick_word();
        case ($urandom_range(9))
            0: return t_word'(WORD_MAX);
            1: return t_word'(WORD_MIN);
            2: return '0;
            3, 4, 5: return t_word'($signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000);
            default: return t_word'($urandom);
        endcase
    endfunction

    // Drives one request and holds it until the unit accepts it. Ready is
    // looked at on the falling edge, where it is settled for the next
    // rising edge. Valid stays high after the accepting edge until the
    // next request or an idle cycle replaces it.
    task automatic send_request(input logic [OP_BITS-1:0] op, input t_word a[3],
                                input t_word b[3]);
        while (!idle_off && $urandom_range(99) < 33) begin
            req_if.valid <= 0;
            @(posedge i_clk);
        end
        req_if.valid  <= 1;
        req_if.opcode <= op;
        req_if.ax <= a[0]; req_if.ay <= a[1]; req_if.az <= a[2];
        req_if.bx <= b[0]; req_if.by <= b[1]; req_if.bz <= b[2];
        @(negedge i_clk);
        while (!req_if.ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Waits until every response is in, then lets the pipeline drain.
    task automatic drain_unit();
        req_if.valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_epsilon(input logic [EPS_BITS-1:0] v);
        i_cfg_we    <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic random_requests(input int n);
        t_word a[3], b[3];
        logic [OP_BITS-1:0] op;
        for (int i = 0; i < n; i++) begin
            for (int k = 0; k < 3; k++) begin
                a[k] = pick_word();
                b[k] = pick_word();
            end
            op = $urandom_range(7);
            // About half of the equality tests use nearby vectors so both answers occur.
            if (op == OP_EQUAL && $urandom_range(1))
                for (int k = 0; k < 3; k++) b[k] = a[k] + $signed($urandom_range(0, 80)) - 40;
            idle_off = (i >= n / 3 && i < n / 2);
            send_request(op, a, b);
        end
        idle_off = 0;
    endtask

    initial begin
        t_word a[3], b[3];
        logic [EPS_BITS-1:0] eps_list[5];
        eps_list = '{16'd0, 16'hffff, 16'd16, 16'd1, 16'd655};
        idle_off = 0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_wdata = '0;
        req_if.valid = 0;
        req_if.opcode = '0;
        {req_if.ax, req_if.ay, req_if.az, req_if.bx, req_if.by, req_if.bz} = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: every opcode on the extremes, with the reset epsilon.
        for (int op = 0; op < 8; op++) begin
            a = '{t_word'(WORD_MAX), t_word'(WORD_MIN), t_word'(WORD_MAX)};
            b = '{t_word'(WORD_MIN), t_word'(WORD_MAX), t_word'(WORD_MIN)};
            send_request(op, a, b);
        end
        // Zero vector: normalize keeps a as it is.
        a = '{t_word'(0), t_word'(0), t_word'(0)};
        send_request(OP_NORM, a, a);
        // Short vector whose length equals epsilon, and vectors of length sqrt(2).
        a = '{t_word'(1), t_word'(0), t_word'(0)};
        send_request(OP_NORM, a, a);
        a = '{t_word'(32'h00010000), t_word'(-32'sh00010000), t_word'(0)};
        b = '{t_word'(0), t_word'(32'h00010000), t_word'(32'h00010000)};
        send_request(OP_NORM, a, b);
        send_request(OP_CROSS, a, b);
        send_request(OP_DOT, a, b);
        send_request(OP_LEN, a, b);
        // Equality at the epsilon boundary: a difference of 0 and of 1.
        send_request(OP_EQUAL, a, a);
        b = '{a[0] + 1, a[1], a[2]};
        send_request(OP_EQUAL, a, b);
        drain_unit();

        // Random phases, each under its own epsilon.
        foreach (eps_list[e]) begin
            write_epsilon(eps_list[e]);
            random_requests(180);
            drain_unit();
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
